[hw/rtl/pca_pkg.sv]
// ----------------------------------------------------------------------------
// pca_pkg
// Widths, constants and controller/datapath command types for the absolute
// correlation unit.
// ----------------------------------------------------------------------------
package pca_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COUNT_W    = 12;
   localparam int SUM_W      = 28;
   localparam int SQ_W       = 42;
   localparam int CROSS_W    = 43;
   localparam int VAL_W      = 56;   // signed holder for num, vx, vy
   localparam int MAG_W      = 55;   // multiplier operand magnitude
   localparam int PROD_W     = 110;  // multiplier product
   localparam int REM_W      = PROD_W + 1;
   localparam int Q_W        = 31;   // quotient before the root
   localparam int RES_W      = 16;
   localparam int STEP_W     = 6;
   localparam int MUL_STEPS  = 55;
   localparam int DIV_STEPS  = 31;
   localparam int SQRT_STEPS = 16;
   localparam int MAX_PAIRS  = 2048;
   localparam logic [RES_W-1:0] ONE_Q15 = 16'h8000;

   typedef enum logic [2:0] {
      OP_N_SXY  = 3'd0,
      OP_SX_SY  = 3'd1,
      OP_N_SXX  = 3'd2,
      OP_SX_SX  = 3'd3,
      OP_N_SYY  = 3'd4,
      OP_SY_SY  = 3'd5,
      OP_NUM_SQ = 3'd6,
      OP_DEN    = 3'd7
   } op_type;

   typedef struct packed {
      logic   acc;
      logic   mul_load;
      logic   mul_store;
      op_type op;
      logic   run;
      logic   div_load;
      logic   sqrt_load;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic sqrt_done;
      logic degenerate;
      logic out_free;
   } stat_type;

endpackage

[hw/rtl/pca_req_if.sv]
// ----------------------------------------------------------------------------
// pca_req_if
// Sample pair channel: valid/ready with one pair per word.
// ----------------------------------------------------------------------------
interface pca_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [pca_pkg::SAMPLE_W-1:0] real_sample;
   logic signed [pca_pkg::SAMPLE_W-1:0] ideal_sample;
   logic                                last;

   modport source(output valid, real_sample, ideal_sample, last, input ready);
   modport sink(input valid, real_sample, ideal_sample, last, output ready);
endinterface

[hw/rtl/pca_rsp_if.sv]
// ----------------------------------------------------------------------------
// pca_rsp_if
// Result channel: valid/ready with one correlation result per word.
// ----------------------------------------------------------------------------
interface pca_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pca_pkg::RES_W-1:0]    correlation_abs;
   logic                         degenerate;
   logic [pca_pkg::COUNT_W-1:0]  pair_count;

   modport source(output valid, correlation_abs, degenerate, pair_count, input ready);
   modport sink(input valid, correlation_abs, degenerate, pair_count, output ready);
endinterface

[hw/rtl/pca_ctrl.sv]
// ----------------------------------------------------------------------------
// pca_ctrl
// Sequencer: accumulate, then run the products, divide and root in turn.
// ----------------------------------------------------------------------------
module pca_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_last,
   output logic              req_ready,
   output pca_pkg::cmd_type  cmd,
   input  pca_pkg::stat_type stat
);

   typedef enum logic [5:0] {
      S_ACC   = 6'b000001,
      S_ISSUE = 6'b000010,
      S_MUL   = 6'b000100,
      S_DIV   = 6'b001000,
      S_SQRT  = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type       state_ff, state_in;
   pca_pkg::op_type op_ff, op_in;
   logic            accept;

   assign req_ready = (state_ff == S_ACC);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      unique case (state_ff)
         S_ACC: begin
            cmd.acc = accept;
            if (accept && req_last) begin
               op_in    = pca_pkg::OP_N_SXY;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            // skip the big products, divide and root when a variance is zero or negative
            if (op_ff == pca_pkg::OP_NUM_SQ && stat.degenerate) begin
               state_in = S_OUT;
            end else begin
               cmd.mul_load = 1'b1;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            cmd.run = 1'b1;
            if (stat.mul_done) begin
               cmd.mul_store = 1'b1;
               if (op_ff == pca_pkg::OP_DEN) begin
                  cmd.div_load = 1'b1;
                  state_in     = S_DIV;
               end else begin
                  op_in    = pca_pkg::op_type'(op_ff + 3'd1);
                  state_in = S_ISSUE;
               end
            end
         end
         S_DIV: begin
            cmd.run = 1'b1;
            if (stat.div_done) begin
               cmd.sqrt_load = 1'b1;
               state_in      = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.run = 1'b1;
            if (stat.sqrt_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_ACC;
            end
         end
         default: state_in = S_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ACC;
         op_ff    <= pca_pkg::OP_N_SXY;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

`ifndef ASSERT_OFF
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last) |=> (state_ff == S_ISSUE))
      else $error("last word did not start the solve");
   a_store_done: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_store |-> stat.mul_done)
      else $error("product stored before the multiplier finished");
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("result loaded over an untaken word");
   a_no_acc_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.acc |-> (state_ff == S_ACC))
      else $error("pair accumulated during the solve");
`endif

endmodule

[hw/rtl/pca_dp.sv]
// ----------------------------------------------------------------------------
// pca_dp
// Sums, shift-add multiplier, restoring divider, bit-serial root and the
// output register.
// ----------------------------------------------------------------------------
module pca_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [pca_pkg::SAMPLE_W-1:0] real_sample,
   input  logic signed [pca_pkg::SAMPLE_W-1:0] ideal_sample,
   input  pca_pkg::cmd_type                    cmd,
   output pca_pkg::stat_type                   stat,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pca_pkg::RES_W-1:0]           rsp_correlation_abs,
   output logic                                rsp_degenerate,
   output logic [pca_pkg::COUNT_W-1:0]         rsp_pair_count
);

   localparam int VW = pca_pkg::VAL_W;

   logic        [pca_pkg::COUNT_W-1:0] pairs_ff;
   logic signed [pca_pkg::SUM_W-1:0]   sum_real_ff, sum_ideal_ff;
   logic        [pca_pkg::SQ_W-1:0]    sum_real_sq_ff, sum_ideal_sq_ff;
   logic signed [pca_pkg::CROSS_W-1:0] sum_cross_ff;

   logic signed [2*pca_pkg::SAMPLE_W-1:0] xx, yy, xy;

   logic signed [VW-1:0] t1_ff, num_ff, vx_ff, vy_ff;
   logic [pca_pkg::PROD_W-1:0] big_a_ff, den_ff;

   logic [pca_pkg::PROD_W-1:0] mul_a_ff, mul_acc_ff;
   logic [pca_pkg::MAG_W-1:0]  mul_b_ff;
   logic                       mul_neg_ff;
   logic [pca_pkg::STEP_W-1:0] cnt_ff;

   logic signed [VW-1:0] opa, opb, abs_a, abs_b;
   logic signed [VW-1:0] prod_lo;

   logic [pca_pkg::REM_W-1:0] rem_ff, rem_sh, den_ext;
   logic [pca_pkg::Q_W-1:0]   div_lo_ff, quot_ff;
   logic                      div_ge;

   logic [pca_pkg::Q_W-1:0] sq_op_ff, sq_res_ff, sq_one_ff, sq_trial;
   logic [pca_pkg::RES_W-1:0] q_val;

   logic div_active_ff, sqrt_active_ff;
   logic mul_phase, phase_done;
   logic step_en;

   assign xx = real_sample * real_sample;
   assign yy = ideal_sample * ideal_sample;
   assign xy = real_sample * ideal_sample;

   // accumulate
   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         pairs_ff        <= '0;
         sum_real_ff     <= '0;
         sum_ideal_ff    <= '0;
         sum_real_sq_ff  <= '0;
         sum_ideal_sq_ff <= '0;
         sum_cross_ff    <= '0;
      end else if (cmd.acc && pairs_ff < pca_pkg::COUNT_W'(pca_pkg::MAX_PAIRS)) begin
         pairs_ff        <= pairs_ff + 1'b1;
         sum_real_ff     <= sum_real_ff + pca_pkg::SUM_W'(real_sample);
         sum_ideal_ff    <= sum_ideal_ff + pca_pkg::SUM_W'(ideal_sample);
         sum_real_sq_ff  <= sum_real_sq_ff + pca_pkg::SQ_W'($unsigned(xx));
         sum_ideal_sq_ff <= sum_ideal_sq_ff + pca_pkg::SQ_W'($unsigned(yy));
         sum_cross_ff    <= sum_cross_ff + pca_pkg::CROSS_W'(xy);
      end
   end

   // operand select
   always_comb begin
      case (cmd.op)
         pca_pkg::OP_N_SXY: begin
            opa = VW'($signed({1'b0, pairs_ff}));
            opb = VW'(sum_cross_ff);
         end
         pca_pkg::OP_SX_SY: begin
            opa = VW'(sum_real_ff);
            opb = VW'(sum_ideal_ff);
         end
         pca_pkg::OP_N_SXX: begin
            opa = VW'($signed({1'b0, pairs_ff}));
            opb = VW'($signed({1'b0, sum_real_sq_ff}));
         end
         pca_pkg::OP_SX_SX: begin
            opa = VW'(sum_real_ff);
            opb = VW'(sum_real_ff);
         end
         pca_pkg::OP_N_SYY: begin
            opa = VW'($signed({1'b0, pairs_ff}));
            opb = VW'($signed({1'b0, sum_ideal_sq_ff}));
         end
         pca_pkg::OP_SY_SY: begin
            opa = VW'(sum_ideal_ff);
            opb = VW'(sum_ideal_ff);
         end
         pca_pkg::OP_NUM_SQ: begin
            opa = num_ff;
            opb = num_ff;
         end
         pca_pkg::OP_DEN: begin
            opa = vx_ff;
            opb = vy_ff;
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
      abs_a = opa[VW-1] ? -opa : opa;
      abs_b = opb[VW-1] ? -opb : opb;
   end

   assign prod_lo = mul_neg_ff ? -$signed(mul_acc_ff[VW-1:0]) : $signed(mul_acc_ff[VW-1:0]);

   // one shared step counter for multiply, divide and root
   always_comb begin
      stat.mul_done   = (cnt_ff == pca_pkg::STEP_W'(pca_pkg::MUL_STEPS));
      stat.div_done   = (cnt_ff == pca_pkg::STEP_W'(pca_pkg::DIV_STEPS));
      stat.sqrt_done  = (cnt_ff == pca_pkg::STEP_W'(pca_pkg::SQRT_STEPS));
      stat.degenerate = (vx_ff == '0) || (vy_ff == '0) || vx_ff[VW-1] || vy_ff[VW-1];
      stat.out_free   = !rsp_valid || rsp_ready;
   end

   // stop the counter only on the end count of the unit that is running
   assign mul_phase  = !div_active_ff && !sqrt_active_ff;
   assign phase_done = div_active_ff  ? stat.div_done  :
                       sqrt_active_ff ? stat.sqrt_done : stat.mul_done;
   assign step_en    = cmd.run && !phase_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.mul_load || cmd.div_load || cmd.sqrt_load) begin
         cnt_ff <= '0;
      end else if (step_en) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // shift-add multiplier, one operand bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         mul_a_ff   <= pca_pkg::PROD_W'(abs_a[pca_pkg::MAG_W-1:0]);
         mul_b_ff   <= abs_b[pca_pkg::MAG_W-1:0];
         mul_acc_ff <= '0;
         mul_neg_ff <= opa[VW-1] ^ opb[VW-1];
      end else if (step_en && mul_phase && mul_b_ff != '0) begin
         if (mul_b_ff[0]) begin
            mul_acc_ff <= mul_acc_ff + mul_a_ff;
         end
         mul_a_ff <= mul_a_ff << 1;
         mul_b_ff <= mul_b_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_store) begin
         case (cmd.op)
            pca_pkg::OP_N_SXY, pca_pkg::OP_N_SXX, pca_pkg::OP_N_SYY: t1_ff <= prod_lo;
            pca_pkg::OP_SX_SY:  num_ff   <= t1_ff - prod_lo;
            pca_pkg::OP_SX_SX:  vx_ff    <= t1_ff - prod_lo;
            pca_pkg::OP_SY_SY:  vy_ff    <= t1_ff - prod_lo;
            pca_pkg::OP_NUM_SQ: big_a_ff <= mul_acc_ff;
            pca_pkg::OP_DEN:    den_ff   <= mul_acc_ff;
            default:            t1_ff    <= t1_ff;
         endcase
      end
   end

   // restoring divide of num^2 * 2^30 by den; quotient fits 31 bits
   assign den_ext = pca_pkg::REM_W'(den_ff);
   assign rem_sh  = {rem_ff[pca_pkg::REM_W-2:0], div_lo_ff[pca_pkg::Q_W-1]};
   assign div_ge  = (rem_sh >= den_ext);

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff    <= pca_pkg::REM_W'(big_a_ff >> 1);
         div_lo_ff <= {big_a_ff[0], (pca_pkg::Q_W-1)'(0)};
         quot_ff   <= '0;
      end else if (step_en && div_active_ff) begin
         rem_ff    <= div_ge ? rem_sh - den_ext : rem_sh;
         div_lo_ff <= div_lo_ff << 1;
         quot_ff   <= {quot_ff[pca_pkg::Q_W-2:0], div_ge};
      end
   end

   // phase flags so each unit steps only in its own phase
   always_ff @(posedge clock) begin
      if (reset) begin
         div_active_ff  <= 1'b0;
         sqrt_active_ff <= 1'b0;
      end else begin
         if (cmd.div_load) begin
            div_active_ff <= 1'b1;
         end else if (cmd.sqrt_load) begin
            div_active_ff <= 1'b0;
         end
         if (cmd.sqrt_load) begin
            sqrt_active_ff <= 1'b1;
         end else if (cmd.out_load || cmd.mul_load) begin
            sqrt_active_ff <= 1'b0;
         end
      end
   end

   // bit-serial integer root, one result bit a cycle
   assign sq_trial = sq_res_ff + sq_one_ff;

   always_ff @(posedge clock) begin
      if (cmd.sqrt_load) begin
         sq_op_ff  <= quot_ff;
         sq_res_ff <= '0;
         sq_one_ff <= pca_pkg::Q_W'(1) << (pca_pkg::Q_W - 1);
      end else if (step_en && sqrt_active_ff) begin
         if (sq_op_ff >= sq_trial) begin
            sq_op_ff  <= sq_op_ff - sq_trial;
            sq_res_ff <= (sq_res_ff >> 1) + sq_one_ff;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
         sq_one_ff <= sq_one_ff >> 2;
      end
   end

   assign q_val = (sq_res_ff > pca_pkg::Q_W'(pca_pkg::ONE_Q15)) ? pca_pkg::ONE_Q15
                                                                : sq_res_ff[pca_pkg::RES_W-1:0];

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_correlation_abs <= stat.degenerate ? '0 : q_val;
         rsp_degenerate      <= stat.degenerate;
         rsp_pair_count      <= pairs_ff;
      end
   end

endmodule

[hw/rtl/pearson_correlation_abs_unit.sv]
// ----------------------------------------------------------------------------
// pearson_correlation_abs_unit
// Absolute correlation of two sample series, unsigned Q1.15 result.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one sample pair per word (real_sample, ideal_sample, last).
//   Pairs are taken one per cycle while accumulating; beyond 2048 pairs they
//   are dropped. The word with last set closes the series.
//   rsp_ch carries one result per series: correlation_abs, degenerate (a
//   variance is zero or negative, result 0) and pair_count.
//   After the last word is taken, the unit runs 8 products (an issue state,
//   then the one-bit-a-cycle shared multiplier), the 31-step divider and
//   the 16-step root, and then loads the output register. With a zero or
//   negative variance the two large products, divide and root are skipped.
//   req_ch.ready is low from the last word until the result is registered.
//   The result sits in an output register; a stalled receiver holds it, and
//   the next series accumulates meanwhile, but the following result waits
//   until that word is taken.
//   Reset (synchronous) clears all sums and drops any pending result.
// ----------------------------------------------------------------------------
module pearson_correlation_abs_unit (
   input logic       clock,
   input logic       reset,
   pca_req_if.sink   req_ch,
   pca_rsp_if.source rsp_ch
);

   pca_pkg::cmd_type  cmd;
   pca_pkg::stat_type stat;

   pca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   pca_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .real_sample         (req_ch.real_sample),
      .ideal_sample        (req_ch.ideal_sample),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_correlation_abs (rsp_ch.correlation_abs),
      .rsp_degenerate      (rsp_ch.degenerate),
      .rsp_pair_count      (rsp_ch.pair_count)
   );

endmodule
